@@ hw/rtl/bounded_deque_with_index_read_defines.svh @@
// assertion macros for the deque rtl files
// no dependencies; included by files that carry concurrent checks
`ifndef BOUNDED_DEQUE_WITH_INDEX_READ_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_INDEX_READ_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BDQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication, disabled while reset is low
`define BDQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

@@ hw/rtl/bdq_pkg.sv @@
// shared types for the bounded deque: operation codes, status codes, ram control
// no dependencies
package bdq_pkg;

    typedef enum logic [2:0] {
        FN_INS_HEAD = 3'd0,
        FN_INS_TAIL = 3'd1,
        FN_RM_HEAD  = 3'd2,
        FN_RM_TAIL  = 3'd3,
        FN_RD_HEAD  = 3'd4,
        FN_RD_TAIL  = 3'd5,
        FN_RD_INDEX = 3'd6
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // ram access strobes from the controller
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

@@ hw/rtl/bdq_ram.sv @@
// single-port slot memory for the deque, registered read
// depends on bdq_pkg for the access strobes
module bdq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  bdq_pkg::t_mem_ctl        i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_addr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bdq_ctrl.sv @@
// deque controller: head pointer, count, op decode, ram access and result register
// depends on bdq_pkg and the assertion macro header
`include "bounded_deque_with_index_read_defines.svh"

module bdq_ctrl #(
    parameter int CAPACITY   = 256,
    parameter int ELEM_WIDTH = 32,
    parameter int PW         = $clog2(CAPACITY),
    parameter int CW         = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_func,
    input  logic [PW-1:0]         i_index,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ELEM_WIDTH-1:0] o_read_data,
    output logic [CW-1:0]         o_count,
    output logic [1:0]            o_status,
    output bdq_pkg::t_mem_ctl     o_mem_ctl,
    output logic [PW-1:0]         o_mem_addr,
    input  logic [ELEM_WIDTH-1:0] i_mem_rdata
);

    localparam logic [CW-1:0] CntFull  = CW'(CAPACITY);
    localparam logic [PW-1:0] PtrLast  = PW'(CAPACITY - 1);
    localparam logic [PW:0]   WrapSize = (PW + 1)'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                r_state, n_state;
    logic [PW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_out_valid;
    logic [ELEM_WIDTH-1:0] r_read_data;
    logic [CW-1:0]         r_out_count;
    bdq_pkg::t_status      r_status, n_status;

    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic          do_write;
    logic          do_read;
    logic [PW-1:0] offset;
    logic [PW:0]   slot_sum;
    logic [PW-1:0] slot;
    logic [PW-1:0] head_dec;
    logic [PW-1:0] head_inc;

    // no transfer is taken while reset is held
    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign is_full    = (r_count == CntFull);
    assign is_empty   = (r_count == '0);
    assign head_dec   = (r_head == '0) ? PtrLast : r_head - 1'b1;
    assign head_inc   = (r_head == PtrLast) ? '0 : r_head + 1'b1;

    // logical offset from head to physical slot, one wrap at most
    always_comb begin
        unique case (bdq_pkg::t_func'(i_func))
            bdq_pkg::FN_INS_TAIL: offset = PW'(r_count);
            bdq_pkg::FN_RD_TAIL:  offset = PW'(r_count - 1'b1);
            bdq_pkg::FN_RD_INDEX: offset = i_index;
            default:              offset = '0;
        endcase
    end

    assign slot_sum = {1'b0, r_head} + {1'b0, offset};
    assign slot     = (slot_sum >= WrapSize) ? PW'(slot_sum - WrapSize) : slot_sum[PW-1:0];

    // operation decode
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = bdq_pkg::ST_OK;
        do_write = 1'b0;
        do_read  = 1'b0;
        unique case (bdq_pkg::t_func'(i_func))
            bdq_pkg::FN_INS_HEAD: begin
                if (is_full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    n_head   = head_dec;
                    n_count  = r_count + 1'b1;
                    do_write = 1'b1;
                end
            end
            bdq_pkg::FN_INS_TAIL: begin
                if (is_full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    n_count  = r_count + 1'b1;
                    do_write = 1'b1;
                end
            end
            bdq_pkg::FN_RM_HEAD: begin
                if (is_empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                end
            end
            bdq_pkg::FN_RM_TAIL: begin
                if (is_empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            bdq_pkg::FN_RD_HEAD, bdq_pkg::FN_RD_TAIL: begin
                if (is_empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    do_read = 1'b1;
                end
            end
            bdq_pkg::FN_RD_INDEX: begin
                if (CW'(i_index) >= r_count) begin
                    n_status = bdq_pkg::ST_RANGE;
                end else begin
                    do_read = 1'b1;
                end
            end
            default: begin
                n_status = bdq_pkg::ST_OK;
            end
        endcase
    end

    // ram access issued in the transfer cycle
    assign o_mem_ctl.wr_en = accept && do_write;
    assign o_mem_ctl.rd_en = accept && do_read;
    assign o_mem_addr      = (bdq_pkg::t_func'(i_func) == bdq_pkg::FN_INS_HEAD) ? head_dec : slot;

    assign n_state = (accept && do_read) ? S_READ : S_IDLE;

    // state, pointers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_READ) begin
                r_out_valid <= 1'b1;
                r_read_data <= i_mem_rdata;
                r_out_count <= r_count;
                r_status    <= bdq_pkg::ST_OK;
            end else if (accept) begin
                r_head  <= n_head;
                r_count <= n_count;
                if (!do_read) begin
                    r_out_valid <= 1'b1;
                    r_read_data <= '0;
                    r_out_count <= n_count;
                    r_status    <= n_status;
                end else if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_count     = r_out_count;
    assign o_status    = r_status;

    // checks
    `BDQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CntFull)
    `BDQ_ASSERT_IMP(a_head_bound, i_clk, i_rst_n, 1'b1, {1'b0, r_head} < WrapSize)
    `BDQ_ASSERT_IMP(a_read_slot_free, i_clk, i_rst_n, r_state == S_READ, !r_out_valid)
    `BDQ_ASSERT_IMP(a_no_dual_access, i_clk, i_rst_n, 1'b1,
        !(o_mem_ctl.wr_en && o_mem_ctl.rd_en))
    `BDQ_ASSERT_NXT(a_reject_holds, i_clk, i_rst_n,
        accept && (n_status != bdq_pkg::ST_OK), $stable(r_count) && $stable(r_head))

endmodule

@@ hw/rtl/bounded_deque_with_index_read.sv @@
// top level of the bounded deque with indexed read
// depends on bdq_pkg, bdq_ctrl and bdq_ram
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one operation per transfer:
//   i_func selects insert head/tail, remove head/tail, read head/tail or read
//   at i_index (counted from the head); i_elem_data is the word to insert.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result per
//   operation: o_read_data (zero unless a successful read), o_count after the
//   operation, and o_status (ok, full, empty, index out of range).
//   Timing: an insert, remove or rejected operation has its result valid in
//   the cycle after the transfer; a successful read passes the registered
//   read of the slot memory and then the result register.
//   Throughput: one item per cycle for inserts and removes while i_out_ready
//   is high; a successful read holds off new items until the result register
//   is loaded from the single memory port in the cycle after the read.
//   Reset clears the head pointer and count; the slot memory is not cleared,
//   since only slots written by inserts are ever read.
//   When the receiver stalls, the result waits in the output register and the
//   input side takes no further item until it is taken or taken that cycle.
module bounded_deque_with_index_read #(
    parameter int CAPACITY   = 256,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [2:0]                       i_func,
    input  logic [ELEM_WIDTH-1:0]            i_elem_data,
    input  logic [$clog2(CAPACITY)-1:0]      i_index,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [ELEM_WIDTH-1:0]            o_read_data,
    output logic [$clog2(CAPACITY + 1)-1:0]  o_count,
    output logic [1:0]                       o_status
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    bdq_pkg::t_mem_ctl     mem_ctl;
    logic [PW-1:0]         mem_addr;
    logic [ELEM_WIDTH-1:0] mem_rdata;

    // control and result path
    bdq_ctrl #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH),
        .PW         (PW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_index     (i_index),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_read_data (o_read_data),
        .o_count     (o_count),
        .o_status    (o_status),
        .o_mem_ctl   (mem_ctl),
        .o_mem_addr  (mem_addr),
        .i_mem_rdata (mem_rdata)
    );

    // slot storage
    bdq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ELEM_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (i_elem_data),
        .o_rdata (mem_rdata)
    );

endmodule
